>>> sv/page_first_fit_allocator_macros.svh
// Assertion macros used by the top level of the page first-fit allocator.
`ifndef PAGE_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define PAGE_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PFFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// Next-cycle implication, checked outside reset.
`define PFFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`endif

>>> sv/pffa_pkg.sv
// Types and constants of the page first-fit allocator.
package pffa_pkg;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_SMALL    = 3'd2;
    localparam logic [2:0] ST_NOSPACE  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_OUTSIDE  = 3'd5;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT  = 2'd2;

    // Opcode values.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Input beat.
    typedef struct packed {
        logic        opcode;
        logic [31:0] size_bytes;
        logic [31:0] address;
    } t_in_beat;

    // Output beat.
    typedef struct packed {
        logic [31:0] result_address;
        logic [2:0]  status;
        logic [10:0] pages_changed;
    } t_out_beat;

endpackage

>>> sv/pffa_bitmap.sv
// Page-use bitmap memory with a clearing pass after reset.
module pffa_bitmap #(
    parameter int NUM_PAGES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(NUM_PAGES)-1:0] i_rd_addr,
    output logic                         o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(NUM_PAGES)-1:0] i_wr_addr,
    input  logic                         i_wr_data,
    output logic                         o_busy
);
    localparam int AW = $clog2(NUM_PAGES);

    logic             r_mem [NUM_PAGES];
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;
    logic             r_rd_data;

    // Clearing pass walks every page once after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (32'(r_clr_addr) == NUM_PAGES - 1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // One write port, shared by the clearing pass and the allocator.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;
endmodule

>>> sv/pffa_table.sv
// Allocation table memory: start page and page count per entry.
module pffa_table #(
    parameter int MAX_ENTRIES = 256,
    parameter int SW          = 10,
    parameter int CNW         = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_rd_addr,
    output logic [SW-1:0]                  o_rd_start,
    output logic [CNW-1:0]                 o_rd_count,
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_wr_addr,
    input  logic [SW-1:0]                  i_wr_start,
    input  logic [CNW-1:0]                 i_wr_count
);
    logic [SW-1:0]  r_start_mem [MAX_ENTRIES];
    logic [CNW-1:0] r_count_mem [MAX_ENTRIES];
    logic [SW-1:0]  r_rd_start;
    logic [CNW-1:0] r_rd_count;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_start_mem[i_wr_addr] <= i_wr_start;
            r_count_mem[i_wr_addr] <= i_wr_count;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_start <= r_start_mem[i_rd_addr];
            r_rd_count <= r_count_mem[i_rd_addr];
        end
    end

    assign o_rd_start = r_rd_start;
    assign o_rd_count = r_rd_count;
endmodule

>>> sv/page_first_fit_allocator.sv
// Top level of the page first-fit allocator.
//
// Input beats carry an opcode with a byte size (allocate) or an address (free).
// Every input beat yields exactly one output beat with an address, a status
// and the number of pages changed. Both channels use valid/ready.
// Configuration registers are written through a plain write port; the user
// must write them only while the block is idle, which the block itself does
// not enforce; they then take effect on the next input beat. One item at a
// time is in work. Rejected items go from the check state through the finish
// state to the output register. An allocate walks the page bitmap one page per
// cycle from page 0 until a long enough free run is found or the region ends,
// then marks one page per cycle. A free walks the allocation table one entry
// per cycle, clears one page per cycle and moves the last entry into the freed
// slot. After reset the bitmap is swept clear; no input beat is taken until
// the sweep ends. A result beat waits in the output register while the
// receiver stalls and the next input beat is still taken; a further result
// waits inside until the register frees.
module page_first_fit_allocator
    import pffa_pkg::*;
#(
    parameter int NUM_PAGES   = 1024,
    parameter int MAX_ENTRIES = 256,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_beat             i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_beat            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    `include "page_first_fit_allocator_macros.svh"

    localparam int PG_SH = $clog2(PAGE_BYTES);
    localparam int AW    = $clog2(NUM_PAGES);
    localparam int PW    = $clog2(NUM_PAGES + 1);
    localparam int EW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int NW    = 32 - PG_SH + 1;
    localparam int LW    = (PW > 11) ? PW : 11;
    localparam int XW    = 34;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_MARK  = 4'd3;
    localparam logic [3:0] S_LOOK  = 4'd4;
    localparam logic [3:0] S_CLR   = 4'd5;
    localparam logic [3:0] S_MVRD  = 4'd6;
    localparam logic [3:0] S_MVWR  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    // Configuration and item registers.
    logic [31:0]   r_base;
    logic [10:0]   r_rpages;
    logic [12:0]   r_small;
    logic          r_op;
    logic [31:0]   r_size;
    logic [31:0]   r_addr;

    // Control state.
    logic [3:0]    r_state;
    logic [PW-1:0] r_need;
    logic [PW-1:0] r_scan_i;
    logic          r_chk_vld;
    logic [AW-1:0] r_chk_i;
    logic [PW-1:0] r_run;
    logic [AW-1:0] r_start;
    logic [AW-1:0] r_mark_i;
    logic [PW-1:0] r_left;
    logic [AW-1:0] r_page;
    logic [CW-1:0] r_eidx;
    logic          r_echk_vld;
    logic [EW-1:0] r_echk;
    logic [EW-1:0] r_hit;
    logic [PW-1:0] r_cnt;
    logic [CW-1:0] r_count;
    logic [PW-1:0] r_used;
    t_out_beat     r_res;
    logic          r_out_valid;
    t_out_beat     r_out;

    // Derived values.
    logic [LW-1:0] w_lim_ext;
    logic [PW-1:0] w_limit;
    logic [31:0]   w_base;
    logic [NW-1:0] w_need;
    logic          w_no_room;
    logic [31:0]   w_off;
    logic [31:0]   w_off_pg;
    logic          w_outside;
    logic [AW-1:0] w_start_now;
    logic          w_found;
    logic          w_fail;
    logic          w_hit;
    logic          w_miss;
    logic [31:0]   w_res_addr;

    // Memory ports.
    logic          w_bm_rd_en;
    logic          w_bm_rd_data;
    logic          w_bm_wr_en;
    logic          w_bm_wr_data;
    logic          w_bm_busy;
    logic          w_tb_rd_en;
    logic [EW-1:0] w_tb_rd_addr;
    logic [AW-1:0] w_tb_rd_start;
    logic [PW-1:0] w_tb_rd_count;
    logic          w_tb_wr_en;
    logic [EW-1:0] w_tb_wr_addr;
    logic [AW-1:0] w_tb_wr_start;
    logic [PW-1:0] w_tb_wr_count;

    // Effective region size and page-aligned base.
    assign w_lim_ext = (LW'(r_rpages) > LW'(NUM_PAGES)) ? LW'(NUM_PAGES) : LW'(r_rpages);
    assign w_limit   = PW'(w_lim_ext);
    assign w_base    = {r_base[31:PG_SH], PG_SH'(0)};

    // Allocate checks: pages needed and room left.
    assign w_need    = NW'(r_size >> PG_SH) + NW'(|r_size[PG_SH-1:0]);
    assign w_no_room = (XW'(r_used) + XW'(w_need) > XW'(w_limit))
                       || (32'(r_count) >= MAX_ENTRIES);

    // Free checks: page offset into the region.
    assign w_off     = r_addr - w_base;
    assign w_off_pg  = w_off >> PG_SH;
    assign w_outside = w_off_pg >= 32'(w_limit);

    // First-fit run tracking on the bitmap read data.
    assign w_start_now = (r_run == '0) ? r_chk_i : r_start;
    assign w_found = (r_state == S_SCAN) && r_chk_vld && !w_bm_rd_data
                     && (r_run + PW'(1) == r_need);
    assign w_fail  = (r_state == S_SCAN) && r_chk_vld && !w_found
                     && (PW'(r_chk_i) + PW'(1) == w_limit);
    assign w_bm_rd_en = (r_state == S_SCAN) && (r_scan_i < w_limit) && !w_found && !w_fail;

    // Table lookup on the read data.
    assign w_hit  = (r_state == S_LOOK) && r_echk_vld && (w_tb_rd_start == r_page);
    assign w_miss = (r_state == S_LOOK) && r_echk_vld && !w_hit
                    && (CW'(r_echk) + CW'(1) == r_count);

    assign w_res_addr = w_base + (32'(r_start) << PG_SH);

    // Bitmap writes: set pages while marking, clear them while freeing.
    assign w_bm_wr_en   = (r_state == S_MARK) || (r_state == S_CLR);
    assign w_bm_wr_data = (r_state == S_MARK);

    // Table port selection.
    always_comb begin
        w_tb_rd_en    = 1'b0;
        w_tb_rd_addr  = EW'(r_eidx);
        w_tb_wr_en    = 1'b0;
        w_tb_wr_addr  = EW'(r_count);
        w_tb_wr_start = w_start_now;
        w_tb_wr_count = r_need;
        if (r_state == S_LOOK) begin
            w_tb_rd_en = (r_eidx < r_count) && !w_hit && !w_miss;
        end else if (r_state == S_MVRD) begin
            w_tb_rd_en   = 1'b1;
            w_tb_rd_addr = EW'(r_count - CW'(1));
        end
        if (w_found) begin
            w_tb_wr_en = 1'b1;
        end else if (r_state == S_MVWR) begin
            w_tb_wr_en    = 1'b1;
            w_tb_wr_addr  = r_hit;
            w_tb_wr_start = w_tb_rd_start;
            w_tb_wr_count = w_tb_rd_count;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_rpages <= 11'd1024;
            r_small  <= 13'd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REGION_BASE:  r_base   <= i_cfg_data;
                CFG_REGION_PAGES: r_rpages <= i_cfg_data[10:0];
                CFG_SMALL_LIMIT:  r_small  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Item payload capture.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op   <= i_in.opcode;
            r_size <= i_in.size_bytes;
            r_addr <= i_in.address;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_used     <= '0;
            r_chk_vld  <= 1'b0;
            r_echk_vld <= 1'b0;
        end else begin
            r_chk_vld  <= w_bm_rd_en;
            r_chk_i    <= AW'(r_scan_i);
            r_echk_vld <= w_tb_rd_en && (r_state == S_LOOK);
            r_echk     <= EW'(r_eidx);
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res.result_address <= '0;
                    r_res.pages_changed  <= '0;
                    r_scan_i <= '0;
                    r_run    <= '0;
                    r_eidx   <= '0;
                    r_page   <= AW'(w_off_pg);
                    r_need   <= PW'(w_need);
                    if (r_op == OP_ALLOC) begin
                        if (r_size == '0) begin
                            r_res.status <= ST_ZERO;
                            r_state      <= S_FIN;
                        end else if (r_size <= 32'(r_small)) begin
                            r_res.status <= ST_SMALL;
                            r_state      <= S_FIN;
                        end else if (w_no_room) begin
                            r_res.status <= ST_NOSPACE;
                            r_state      <= S_FIN;
                        end else begin
                            r_res.status <= ST_OK;
                            r_state      <= S_SCAN;
                        end
                    end else begin
                        if (w_outside) begin
                            r_res.status <= ST_OUTSIDE;
                            r_state      <= S_FIN;
                        end else if (r_count == '0) begin
                            r_res.status <= ST_NOTFOUND;
                            r_state      <= S_FIN;
                        end else begin
                            r_res.status <= ST_OK;
                            r_state      <= S_LOOK;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_bm_rd_en) begin
                        r_scan_i <= r_scan_i + PW'(1);
                    end
                    if (w_found) begin
                        r_start  <= w_start_now;
                        r_mark_i <= w_start_now;
                        r_left   <= r_need;
                        r_state  <= S_MARK;
                    end else if (w_fail) begin
                        r_res.status <= ST_NOSPACE;
                        r_state      <= S_FIN;
                    end else if (r_chk_vld) begin
                        if (w_bm_rd_data) begin
                            r_run <= '0;
                        end else begin
                            r_start <= w_start_now;
                            r_run   <= r_run + PW'(1);
                        end
                    end
                end
                S_MARK: begin
                    r_mark_i <= r_mark_i + AW'(1);
                    r_left   <= r_left - PW'(1);
                    if (r_left == PW'(1)) begin
                        r_count <= r_count + CW'(1);
                        r_used  <= r_used + r_need;
                        r_res   <= '{result_address: w_res_addr, status: ST_OK,
                                     pages_changed: 11'(r_need)};
                        r_state <= S_FIN;
                    end
                end
                S_LOOK: begin
                    if (w_tb_rd_en) begin
                        r_eidx <= r_eidx + CW'(1);
                    end
                    if (w_hit) begin
                        r_hit    <= r_echk;
                        r_cnt    <= w_tb_rd_count;
                        r_mark_i <= r_page;
                        r_left   <= w_tb_rd_count;
                        r_state  <= S_CLR;
                    end else if (w_miss) begin
                        r_res.status <= ST_NOTFOUND;
                        r_state      <= S_FIN;
                    end
                end
                S_CLR: begin
                    r_mark_i <= r_mark_i + AW'(1);
                    r_left   <= r_left - PW'(1);
                    if (r_left <= PW'(1)) begin
                        r_state <= S_MVRD;
                    end
                end
                S_MVRD: begin
                    r_state <= S_MVWR;
                end
                S_MVWR: begin
                    r_count <= r_count - CW'(1);
                    r_used  <= (r_used >= r_cnt) ? r_used - r_cnt : '0;
                    r_res   <= '{result_address: '0, status: ST_OK,
                                 pages_changed: 11'(r_cnt)};
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && (!r_out_valid || i_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && (!r_out_valid || i_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !w_bm_busy;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // Page-use bitmap.
    pffa_bitmap #(
        .NUM_PAGES (NUM_PAGES)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_bm_rd_en),
        .i_rd_addr (AW'(r_scan_i)),
        .o_rd_data (w_bm_rd_data),
        .i_wr_en   (w_bm_wr_en),
        .i_wr_addr (r_mark_i),
        .i_wr_data (w_bm_wr_data),
        .o_busy    (w_bm_busy)
    );

    // Allocation table.
    pffa_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SW          (AW),
        .CNW         (PW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rd_en    (w_tb_rd_en),
        .i_rd_addr  (w_tb_rd_addr),
        .o_rd_start (w_tb_rd_start),
        .o_rd_count (w_tb_rd_count),
        .i_wr_en    (w_tb_wr_en),
        .i_wr_addr  (w_tb_wr_addr),
        .i_wr_start (w_tb_wr_start),
        .i_wr_count (w_tb_wr_count)
    );

    // Checks on the bookkeeping and the sequencer.
    `PFFA_ASSERT_NOW(a_used_bound, 1'b1, 32'(r_used) <= NUM_PAGES)
    `PFFA_ASSERT_NOW(a_count_bound, 1'b1, 32'(r_count) <= MAX_ENTRIES)
    `PFFA_ASSERT_NEXT(a_accept_starts, i_valid && o_ready, r_state == S_CHECK)
    `PFFA_ASSERT_NOW(a_mark_left, r_state == S_MARK, r_left != '0)
endmodule

>>> bench/tb_page_first_fit_allocator.sv
// Self-checking testbench of the page first-fit allocator with its own predictor.
`timescale 1ns / 100ps

module tb_page_first_fit_allocator;
    import pffa_pkg::*;

    localparam int NUM_PAGES   = 1024;
    localparam int MAX_ENTRIES = 256;
    localparam int PAGE_BYTES  = 4096;
    localparam int STALL_LIMIT = 20000;

    // Ways of making random beats.
    typedef enum int {GEN_MIXED, GEN_FILL, GEN_DRAIN} t_gen_mode;

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_in_beat             i_in;
    logic                 o_valid;
    logic                 i_ready;
    t_out_beat            o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;

    page_first_fit_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted allocator state and registers.
    bit [NUM_PAGES-1:0] page_map;
    int                 alloc_start[$];
    int                 alloc_len[$];
    int                 pages_in_use;
    logic [31:0]        base_reg;
    logic [10:0]        pages_reg;
    logic [12:0]        small_reg;

    t_row      directed_rows[$];
    t_out_beat expected_results[$];
    int        random_left;
    t_gen_mode gen_mode;
    int        send_idle;
    int        recv_stall;
    int        errors;
    int        quiet_cycles;
    int        status_seen[8];
    int        beats_in;
    t_row      cur_row;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h, want 0x%08h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int usable_pages();
        return (pages_reg > NUM_PAGES) ? NUM_PAGES : int'(pages_reg);
    endfunction

    function automatic logic [31:0] page_base();
        return {base_reg[31:12], 12'h000};
    endfunction

    // Works out the result of one beat and updates the predicted state.
    function automatic t_out_beat allocate_or_release(input t_in_beat b);
        t_out_beat      r;
        int             lim;
        longint         need;
        longint         span;
        int             run;
        int             first;
        bit             found;
        logic [31:0]    off;
        int             page;
        int             idx;
        r     = '0;
        lim   = usable_pages();
        run   = 0;
        first = 0;
        found = 0;
        idx   = -1;
        if (b.opcode == OP_ALLOC) begin
            if (b.size_bytes == 0) begin
                r.status = ST_ZERO;
            end else if (b.size_bytes <= small_reg) begin
                r.status = ST_SMALL;
            end else begin
                need = (longint'(b.size_bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
                if (pages_in_use + need > lim || alloc_start.size() >= MAX_ENTRIES) begin
                    r.status = ST_NOSPACE;
                end else begin
                    // First fit over the pages of the current region.
                    for (int i = 0; i < lim; i++) begin
                        if (page_map[i]) begin
                            run = 0;
                        end else begin
                            if (run == 0) first = i;
                            run++;
                            if (run == need) begin
                                found = 1;
                                break;
                            end
                        end
                    end
                    if (!found) begin
                        r.status = ST_NOSPACE;
                    end else begin
                        for (int i = 0; i < run; i++) page_map[first + i] = 1'b1;
                        alloc_start.push_back(first);
                        alloc_len.push_back(run);
                        pages_in_use += run;
                        r.status         = ST_OK;
                        r.result_address = page_base() + 32'(first) * PAGE_BYTES;
                        r.pages_changed  = 11'(run);
                    end
                end
            end
        end else begin
            off  = b.address - page_base();
            span = longint'(lim) * PAGE_BYTES;
            if (longint'(off) >= span) begin
                r.status = ST_OUTSIDE;
            end else begin
                page = int'(off / PAGE_BYTES);
                foreach (alloc_start[k]) if (idx < 0 && alloc_start[k] == page) idx = k;
                if (idx < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    for (int i = 0; i < alloc_len[idx]; i++)
                        if (page + i < NUM_PAGES) page_map[page + i] = 1'b0;
                    pages_in_use -= alloc_len[idx];
                    r.status        = ST_OK;
                    r.pages_changed = 11'(alloc_len[idx]);
                    alloc_start.delete(idx);
                    alloc_len.delete(idx);
                end
            end
        end
        return r;
    endfunction

    // Address somewhere inside the start page of a live allocation.
    function automatic logic [31:0] live_address();
        int k;
        k = $urandom_range(alloc_start.size() - 1);
        return page_base() + 32'(alloc_start[k]) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
    endfunction

    function automatic t_in_beat random_request();
        t_in_beat b;
        int       pick;
        b.opcode     = OP_ALLOC;
        b.size_bytes = $urandom;
        b.address    = $urandom;
        pick         = $urandom_range(99);
        if (gen_mode == GEN_FILL) begin
            b.size_bytes = $urandom_range(PAGE_BYTES + 1, 2 * PAGE_BYTES);
        end else if (gen_mode == GEN_DRAIN || pick < 40) begin
            b.opcode = OP_FREE;
            if (alloc_start.size() > 0) b.address = live_address();
        end else if (pick < 78) begin
            b.size_bytes = $urandom_range(1, 6) * PAGE_BYTES - $urandom_range(PAGE_BYTES - 1);
        end else if (pick < 82) begin
            b.size_bytes = 0;
        end else if (pick < 87) begin
            b.size_bytes = $urandom_range(small_reg);
        end else if (pick < 93) begin
            b.opcode  = OP_FREE;
            b.address = page_base() + $urandom_range(NUM_PAGES * PAGE_BYTES + PAGE_BYTES);
        end else if (pick < 96) begin
            b.opcode = OP_FREE;
        end
        return b;
    endfunction

    // Input side: drives beats and predicts each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                if (cur_row.typed) begin
                    void'(allocate_or_release(cur_row.beat));
                    expected_results.push_back(cur_row.want);
                end else begin
                    expected_results.push_back(allocate_or_release(cur_row.beat));
                end
                beats_in++;
            end
            if (!i_valid || o_ready) begin
                if ((directed_rows.size() > 0 || random_left > 0) &&
                    $urandom_range(99) >= send_idle) begin
                    if (directed_rows.size() > 0) begin
                        cur_row = directed_rows.pop_front();
                    end else begin
                        cur_row.beat  = random_request();
                        cur_row.typed = 0;
                        random_left--;
                    end
                    i_in    <= cur_row.beat;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls, field checks and the watchdog.
    always @(posedge i_clk) begin
        t_out_beat want;
        i_ready <= ($urandom_range(99) >= recv_stall);
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", 32'(o_out.status), 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    status_seen[want.status]++;
                    if (o_out.result_address !== want.result_address)
                        report_mismatch("result_address", o_out.result_address,
                                        want.result_address);
                    if (o_out.status !== want.status)
                        report_mismatch("status", 32'(o_out.status), 32'(want.status));
                    if (o_out.pages_changed !== want.pages_changed)
                        report_mismatch("pages_changed", 32'(o_out.pages_changed),
                                        32'(want.pages_changed));
                end
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet_cycles = 0;
            end else if (++quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding",
                         expected_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic add_row(input logic op, input logic [31:0] size, input logic [31:0] addr,
                           input bit typed, input logic [2:0] st, input logic [31:0] res,
                           input int pages);
        t_row row;
        row.beat.opcode           = op;
        row.beat.size_bytes       = size;
        row.beat.address          = addr;
        row.typed                 = typed;
        row.want.result_address   = res;
        row.want.status           = st;
        row.want.pages_changed    = 11'(pages);
        directed_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_REGION_BASE:  base_reg  = data;
            CFG_REGION_PAGES: pages_reg = data[10:0];
            default:          small_reg = data[12:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] base, input logic [31:0] pages,
                            input logic [31:0] limit);
        write_reg(CFG_REGION_BASE, base);
        write_reg(CFG_REGION_PAGES, pages);
        write_reg(CFG_SMALL_LIMIT, limit);
    endtask

    // Waits until every beat is sent and every result has come back.
    // The state is looked at on the falling edge, after the rising-edge updates.
    task automatic wait_drained();
        @(negedge i_clk);
        while (directed_rows.size() > 0 || random_left > 0 || i_valid ||
               expected_results.size() > 0)
            @(negedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input t_gen_mode mode);
        gen_mode    = mode;
        random_left = count;
        wait_drained();
    endtask

    // Register settings visited by the random phases, extremes included.
    logic [31:0] cfg_base[8]  = '{32'h0, 32'hFFFFF000, 32'h1234_5ABC, 32'hFFFFFFFF,
                                  32'h8000_0000, 32'h0, 32'h00FF_F001, 32'h4000_0000};
    logic [31:0] cfg_pages[8] = '{11'd1024, 11'd16, 11'd2047, 11'd1, 11'd64, 11'd0,
                                  11'd300, 11'd1024};
    logic [31:0] cfg_small[8] = '{13'd2048, 13'd0, 13'd4096, 13'd8191, 13'd100,
                                  13'd2048, 13'd5000, 13'd0};

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_ready     <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_REGION_BASE;
        i_cfg_data  <= '0;
        base_reg     = 32'h0;
        pages_reg    = 11'd1024;
        small_reg    = 13'd2048;
        page_map     = '0;
        pages_in_use = 0;
        errors       = 0;
        quiet_cycles = 0;
        beats_in     = 0;
        random_left  = 0;
        gen_mode     = GEN_MIXED;
        send_idle    = 0;
        recv_stall   = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats with the reset register values.
        add_row(OP_ALLOC, 32'd0,        '0, 1, ST_ZERO,     32'h0,     0);
        add_row(OP_ALLOC, 32'd2048,     '0, 1, ST_SMALL,    32'h0,     0);
        add_row(OP_ALLOC, 32'd2049,     '0, 1, ST_OK,       32'h0,     1);
        add_row(OP_ALLOC, 32'hFFFFFFFF, '0, 1, ST_NOSPACE,  32'h0,     0);
        add_row(OP_ALLOC, 32'h003FF000, '0, 1, ST_OK,       32'h1000,  1023);
        add_row(OP_ALLOC, 32'd4097,     '0, 1, ST_NOSPACE,  32'h0,     0);
        add_row(OP_FREE,  '0, 32'hFFFFFFFF, 1, ST_OUTSIDE,  32'h0,     0);
        add_row(OP_FREE,  '0, 32'h00400000, 1, ST_OUTSIDE,  32'h0,     0);
        add_row(OP_FREE,  '0, 32'h00002000, 1, ST_NOTFOUND, 32'h0,     0);
        add_row(OP_FREE,  '0, 32'h00000FFF, 1, ST_OK,       32'h0,     1);
        add_row(OP_ALLOC, 32'd8192,     '0, 1, ST_NOSPACE,  32'h0,     0);
        add_row(OP_FREE,  '0, 32'h00001ABC, 1, ST_OK,       32'h0,     1023);
        add_row(OP_ALLOC, 32'd4096,     '0, 1, ST_OK,       32'h0,     1);
        add_row(OP_ALLOC, 32'd12288,    '0, 1, ST_OK,       32'h1000,  3);
        add_row(OP_FREE,  '0, 32'h00000000, 1, ST_OK,       32'h0,     1);
        add_row(OP_ALLOC, 32'd8192,     '0, 0, ST_OK,       32'h0,     0);
        add_row(OP_ALLOC, 32'd4096,     '0, 0, ST_OK,       32'h0,     0);
        add_row(OP_FREE,  '0, 32'h00001000, 0, ST_OK,       32'h0,     0);
        add_row(OP_FREE,  '0, 32'h00004000, 0, ST_OK,       32'h0,     0);
        add_row(OP_FREE,  '0, 32'h00000000, 0, ST_OK,       32'h0,     0);
        wait_drained();

        // Fill the allocation table past its end at the top of the address space.
        set_regs(32'hFFFFF000, 32'd1024, 32'd4096);
        run_random(MAX_ENTRIES + 2, GEN_FILL);
        run_random(MAX_ENTRIES, GEN_DRAIN);

        // Random traffic under each idling pattern and several register settings.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 56 : 30) : 0;
            recv_stall = (ph == 2) ? 56 : ((ph == 3) ? 30 : 0);
            for (int c = 0; c < 2; c++) begin
                set_regs(cfg_base[2*ph + c], cfg_pages[2*ph + c], cfg_small[2*ph + c]);
                run_random(90, GEN_MIXED);
                // The second batch starts only after every result is back.
                run_random(90, GEN_MIXED);
            end
        end

        repeat (64) @(posedge i_clk);
        $display("Covered %0d beats: %0d ok, %0d zero, %0d small, %0d no space,",
                 beats_in, status_seen[ST_OK], status_seen[ST_ZERO],
                 status_seen[ST_SMALL], status_seen[ST_NOSPACE]);
        $display("%0d not found and %0d outside, over 8 register settings and 4 idling patterns.",
                 status_seen[ST_NOTFOUND], status_seen[ST_OUTSIDE]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
